/* src/crc32fac_pkg.sv */
// Shared types, constants and the byte-wide CRC-32 update for the frame CRC block.
`timescale 1ns / 1ps

package crc32fac_pkg;

  localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
  localparam int unsigned MAX_RES = 5;

  // One result transaction as it leaves the block
  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       frame_end;
    logic       frame_ok;
    logic       run_last;
  } res_t;

  // MSB-first CRC-32 update over one byte, no reflection
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {b, 24'h00_0000};
    for (int i = 0; i < 8; i++) begin
      if (c[31]) begin
        c = {c[30:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[30:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* src/crc32_frame_append_check.sv */
// Top level: CRC-32 frame append / strip-and-check on a byte stream.
// A result goes from its input transaction straight into the output register, if out is free.
// Throughput: one byte per cycle while the output keeps up; the input stalls while queued results
// drain, as after a final byte in append mode (five results) or in check mode with a full holder.
// The pending queue (five entries) and the output register part the two sides.
// Reset (rst_n low, synchronous) clears check_mode, the CRC, the holder and both queues.
`timescale 1ns / 1ps

module crc32_frame_append_check
  import crc32fac_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  // configuration
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,   // check_mode
  // input stream
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,      // [7:0] data_byte
  input  logic       in_tlast,      // frame_last
  // result stream
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [15:0] out_tdata,    // [7:0] out_byte, [8] frame_ok, [9] run_last, zero pad
  output logic       out_tlast,     // frame_end
  output logic       out_tuser      // has_byte
);

  logic        mode_r, mode_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [7:0]  hold_r   [4];
  logic [7:0]  hold_nxt [4];
  logic [2:0]  hcnt_r, hcnt_nxt;

  res_t        out_r, out_nxt;
  logic        out_valid_r, out_valid_nxt;
  res_t        pend_r   [MAX_RES];
  res_t        pend_nxt [MAX_RES];
  logic [2:0]  pend_cnt_r, pend_cnt_nxt;

  res_t        res [MAX_RES];
  logic [2:0]  res_n;
  logic [31:0] crc_upd;
  logic [7:0]  crc_src;
  logic [31:0] rx_crc;
  logic        full;
  logic        in_fire;
  logic        slot_free;

  assign in_tready = (pend_cnt_r == 3'd0);
  assign in_fire   = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;
  assign full      = (hcnt_r >= 3'd4);

  // Feed the CRC with the incoming byte in append mode, the oldest held byte in check mode
  assign crc_src = mode_r ? hold_r[0] : in_tdata;
  assign crc_upd = crc32_byte(crc_r, crc_src);
  assign rx_crc  = {hold_r[1], hold_r[2], hold_r[3], in_tdata};

  // Build the results of the byte at the input
  always_comb begin
    for (int i = 0; i < MAX_RES; i++) begin
      res[i] = '0;
    end
    res_n = 3'd0;
    if (!mode_r) begin
      res[0] = '{out_byte: in_tdata, has_byte: 1'b1, frame_end: 1'b0, frame_ok: 1'b0,
                 run_last: !in_tlast};
      res[1] = '{out_byte: crc_upd[31:24], has_byte: 1'b1, frame_end: 1'b0,
                 frame_ok: 1'b0, run_last: 1'b0};
      res[2] = '{out_byte: crc_upd[23:16], has_byte: 1'b1, frame_end: 1'b0,
                 frame_ok: 1'b0, run_last: 1'b0};
      res[3] = '{out_byte: crc_upd[15:8], has_byte: 1'b1, frame_end: 1'b0,
                 frame_ok: 1'b0, run_last: 1'b0};
      res[4] = '{out_byte: crc_upd[7:0], has_byte: 1'b1, frame_end: 1'b1,
                 frame_ok: 1'b0, run_last: 1'b1};
      res_n  = in_tlast ? 3'd5 : 3'd1;
    end else if (full) begin
      res[0] = '{out_byte: hold_r[0], has_byte: 1'b1, frame_end: 1'b0, frame_ok: 1'b0,
                 run_last: !in_tlast};
      res[1] = '{out_byte: 8'h00, has_byte: 1'b0, frame_end: 1'b1,
                 frame_ok: (rx_crc == crc_upd), run_last: 1'b1};
      res_n  = in_tlast ? 3'd2 : 3'd1;
    end else begin
      // holder still filling: only a failed status at frame end
      res[0] = '{out_byte: 8'h00, has_byte: 1'b0, frame_end: 1'b1, frame_ok: 1'b0,
                 run_last: 1'b1};
      res_n  = in_tlast ? 3'd1 : 3'd0;
    end
  end

  // Advance CRC and holder state
  always_comb begin
    mode_nxt = mode_r;
    crc_nxt  = crc_r;
    hcnt_nxt = hcnt_r;
    for (int i = 0; i < 4; i++) begin
      hold_nxt[i] = hold_r[i];
    end
    if (cfg_wr_en) begin
      mode_nxt = cfg_wr_data;
      crc_nxt  = '0;
      hcnt_nxt = '0;
      for (int i = 0; i < 4; i++) begin
        hold_nxt[i] = '0;
      end
    end else if (in_fire) begin
      if (!mode_r) begin
        crc_nxt = crc_upd;
      end else if (full) begin
        crc_nxt     = crc_upd;
        hold_nxt[0] = hold_r[1];
        hold_nxt[1] = hold_r[2];
        hold_nxt[2] = hold_r[3];
        hold_nxt[3] = in_tdata;
        hcnt_nxt    = 3'd5;
      end else begin
        hold_nxt[hcnt_r[1:0]] = in_tdata;
        hcnt_nxt = hcnt_r + 3'd1;
      end
      // drop frame state after the final byte
      if (in_tlast) begin
        crc_nxt  = '0;
        hcnt_nxt = '0;
        for (int i = 0; i < 4; i++) begin
          hold_nxt[i] = '0;
        end
      end
    end
  end

  // Move results through the pending queue into the output register
  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    pend_cnt_nxt  = pend_cnt_r;
    for (int i = 0; i < MAX_RES; i++) begin
      pend_nxt[i] = pend_r[i];
    end
    if (slot_free) begin
      if (pend_cnt_r != 3'd0) begin
        out_nxt       = pend_r[0];
        out_valid_nxt = 1'b1;
        for (int i = 0; i < MAX_RES - 1; i++) begin
          pend_nxt[i] = pend_r[i + 1];
        end
        pend_cnt_nxt = pend_cnt_r - 3'd1;
      end else if (in_fire && res_n != 3'd0) begin
        out_nxt       = res[0];
        out_valid_nxt = 1'b1;
        for (int i = 0; i < MAX_RES - 1; i++) begin
          pend_nxt[i] = res[i + 1];
        end
        pend_cnt_nxt = res_n - 3'd1;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (in_fire && res_n != 3'd0) begin
      // output stalled: park every result
      for (int i = 0; i < MAX_RES; i++) begin
        pend_nxt[i] = res[i];
      end
      pend_cnt_nxt = res_n;
    end
  end

  // Control and frame state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= 1'b0;
      crc_r       <= '0;
      hcnt_r      <= '0;
      out_valid_r <= 1'b0;
      pend_cnt_r  <= '0;
      for (int i = 0; i < 4; i++) begin
        hold_r[i] <= '0;
      end
    end else begin
      mode_r      <= mode_nxt;
      crc_r       <= crc_nxt;
      hcnt_r      <= hcnt_nxt;
      out_valid_r <= out_valid_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
      for (int i = 0; i < 4; i++) begin
        hold_r[i] <= hold_nxt[i];
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    for (int i = 0; i < MAX_RES; i++) begin
      pend_r[i] <= pend_nxt[i];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b00_0000, out_r.run_last, out_r.frame_ok, out_r.out_byte};
  assign out_tlast  = out_r.frame_end;
  assign out_tuser  = out_r.has_byte;

`ifndef SYNTHESIS
  // A queued result never waits behind an empty output register
  a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> pend_cnt_r == 3'd0)
    else $error("pending results behind an empty output register");

  // An append-mode final byte queues its four CRC bytes
  a_append_tail: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_tlast && !mode_r && !cfg_wr_en |=> out_valid_r && pend_cnt_r >= 3'd4)
    else $error("append tail not queued");

  // Check mode folds nothing into the CRC until the holder has spilled
  a_crc_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r && hcnt_r != 3'd5 |-> crc_r == 32'h0000_0000)
    else $error("CRC advanced while the holder was filling");

  // The holder is unused in append mode and never counts past five
  a_hold_range: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r || hcnt_r == 3'd0) && (hcnt_r <= 3'd5))
    else $error("holder count out of range");
`endif

endmodule

/* tb/tb.sv */
// Self-checking testbench for the CRC-32 frame append / strip-and-check block.
`timescale 1ns / 1ps

module tb;
  import crc32fac_pkg::*;

  // Track the block's frame state and hold the results it should produce, oldest first
  class frame_crc_sb;
    bit          check_mode;
    logic [31:0] crc_acc;
    logic [7:0]  hold_q [4];
    int unsigned held;
    res_t        exp_q [$];
    int          errors;

    function new();
      check_mode = 1'b0;
      errors     = 0;
      clear_frame();
    endfunction

    // Bit-serial MSB-first CRC-32, one byte
    static function logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
      logic fb;
      for (int i = 7; i >= 0; i--) begin
        fb = c[31] ^ b[i];
        c  = c << 1;
        if (fb) begin
          c = c ^ CRC_POLY;
        end
      end
      return c;
    endfunction

    function void clear_frame();
      crc_acc = '0;
      held    = 0;
      for (int i = 0; i < 4; i++) begin
        hold_q[i] = '0;
      end
    endfunction

    // A mode write drops whatever frame was in progress
    function void set_mode(bit m);
      check_mode = m;
      clear_frame();
    endfunction

    function res_t make_res(logic [7:0] b, bit hb, bit fe, bit ok);
      res_t r;
      r.out_byte  = b;
      r.has_byte  = hb;
      r.frame_end = fe;
      r.frame_ok  = ok;
      r.run_last  = 1'b0;
      return r;
    endfunction

    // Work out the results of one accepted input transaction
    function void note_input(logic [7:0] b, bit last);
      res_t        batch [$];
      logic [31:0] rx;
      if (!check_mode) begin
        crc_acc = crc_step(crc_acc, b);
        batch.push_back(make_res(b, 1'b1, 1'b0, 1'b0));
        if (last) begin
          for (int k = 3; k >= 0; k--) begin
            batch.push_back(make_res(crc_acc[8*k +: 8], 1'b1, k == 0, 1'b0));
          end
          clear_frame();
        end
      end else begin
        // Release the oldest held byte once the holder is full
        if (held >= 4) begin
          crc_acc = crc_step(crc_acc, hold_q[0]);
          batch.push_back(make_res(hold_q[0], 1'b1, 1'b0, 1'b0));
          hold_q[0] = hold_q[1];
          hold_q[1] = hold_q[2];
          hold_q[2] = hold_q[3];
          hold_q[3] = b;
          held      = 5;
        end else begin
          hold_q[held] = b;
          held         = held + 1;
        end
        if (last) begin
          rx = {hold_q[0], hold_q[1], hold_q[2], hold_q[3]};
          batch.push_back(make_res(8'h00, 1'b0, 1'b1, (held == 5) && (rx == crc_acc)));
          clear_frame();
        end
      end
      if (batch.size() > 0) begin
        batch[batch.size() - 1].run_last = 1'b1;
      end
      foreach (batch[i]) begin
        exp_q.push_back(batch[i]);
      end
    endfunction

    // Compare one result transaction with the oldest expectation
    function void check_result(logic [7:0] b, bit hb, bit fe, bit ok, bit rl);
      res_t want;
      if (exp_q.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("%0t: unexpected result byte=%02h has_byte=%0b end=%0b ok=%0b run_last=%0b",
                   $realtime, b, hb, fe, ok, rl);
        end
        return;
      end
      want = exp_q.pop_front();
      if (want.out_byte !== b || want.has_byte !== hb || want.frame_end !== fe ||
          want.frame_ok !== ok || want.run_last !== rl) begin
        errors++;
        if (errors <= 10) begin
          $display("%0t: mismatch exp byte=%02h hb=%0b end=%0b ok=%0b rl=%0b",
                   $realtime, want.out_byte, want.has_byte, want.frame_end,
                   want.frame_ok, want.run_last);
          $display("%0t:          got byte=%02h hb=%0b end=%0b ok=%0b rl=%0b",
                   $realtime, b, hb, fe, ok, rl);
        end
      end
    endfunction
  endclass

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        cfg_wr_en   = 1'b0;
  logic        cfg_wr_data = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic [7:0]  in_tdata    = 8'h00;
  logic        in_tlast    = 1'b0;
  logic        out_tready  = 1'b0;
  logic        in_tready;
  logic        out_tvalid;
  logic [15:0] out_tdata;
  logic        out_tlast;
  logic        out_tuser;

  frame_crc_sb sb;
  bit          calm;
  int          holdoff_req;
  logic [7:0]  frame_buf [$];
  int          random_bytes;

  crc32_frame_append_check u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser)
  );

  always #5 clk = ~clk;

  // Check every result transaction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(out_tdata[7:0], out_tuser, out_tlast, out_tdata[8], out_tdata[9]);
    end
  end

  // Receiver: random stalls, or a long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (holdoff_req != 0) begin
        holdoff_req = 0;
        out_tready <= 1'b0;
        repeat (60) @(negedge clk);
      end else begin
        out_tready <= calm || ($urandom_range(0, 99) >= 15);
      end
    end
  end

  // Offer one byte, with random gaps ahead of it, and hold until accepted
  task automatic send_byte(input logic [7:0] b, input bit last);
    while (!calm && $urandom_range(0, 99) < 15) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(b, last);
    @(negedge clk);
  endtask

  task automatic send_frame();
    foreach (frame_buf[i]) begin
      send_byte(frame_buf[i], i == frame_buf.size() - 1);
    end
  endtask

  // Send the buffer with no last marker, leaving the frame open
  task automatic send_open();
    foreach (frame_buf[i]) begin
      send_byte(frame_buf[i], 1'b0);
    end
  endtask

  // Stop offering, wait for every expected result, then let the pipeline empty
  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.exp_q.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_mode(input bit m);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    sb.set_mode(m);
  endtask

  // Build payload plus its big-endian CRC
  task automatic make_good(input int len);
    logic [31:0] c;
    logic [7:0]  b;
    frame_buf.delete();
    c = '0;
    repeat (len) begin
      b = 8'($urandom_range(0, 255));
      frame_buf.push_back(b);
      c = frame_crc_sb::crc_step(c, b);
    end
    for (int k = 3; k >= 0; k--) begin
      frame_buf.push_back(c[8*k +: 8]);
    end
  endtask

  task automatic make_random(input int len);
    frame_buf.delete();
    repeat (len) frame_buf.push_back(8'($urandom_range(0, 255)));
  endtask

  function automatic int pick_len();
    if ($urandom_range(0, 9) == 0) begin
      return $urandom_range(16, 40);
    end
    return $urandom_range(1, 8);
  endfunction

  // Run limit
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int ph;
    int nframes;
    int r;
    int idx;
    sb           = new();
    calm         = 1'b0;
    holdoff_req  = 0;
    random_bytes = 0;
    rst_n        = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Append mode: short frames at the byte extremes
    frame_buf = '{8'h00};
    send_frame();
    frame_buf = '{8'hFF, 8'hA5};
    send_frame();

    // Check mode: short frames, a good frame and a corrupted one
    write_mode(1'b1);
    frame_buf = '{8'h5A};
    send_frame();
    make_good(0);
    send_frame();
    make_good(1);
    send_frame();
    make_good(1);
    frame_buf[4] ^= 8'h01;
    send_frame();

    // Abort open frames by mode writes in both modes
    frame_buf = '{8'h11, 8'h22, 8'h33};
    send_open();
    write_mode(1'b0);
    frame_buf = '{8'h44, 8'h55};
    send_open();
    write_mode(1'b1);

    // Random phases, alternating mode
    for (ph = 0; ph < 6; ph++) begin
      write_mode(ph[0]);
      calm    = (ph == 4);
      nframes = 0;
      while (random_bytes < (ph + 1) * 85) begin
        if (ph == 2 && nframes == 3) begin
          holdoff_req = 1;
        end
        if (ph == 3 && nframes == 4) begin
          settle();
        end
        if (!ph[0]) begin
          make_random(pick_len());
        end else begin
          r = $urandom_range(0, 99);
          if (r < 70) begin
            make_good(pick_len());
          end else if (r < 85) begin
            make_good(pick_len());
            idx = $urandom_range(0, frame_buf.size() - 1);
            frame_buf[idx] ^= 8'(1 << $urandom_range(0, 7));
          end else begin
            make_random($urandom_range(1, 6));
          end
        end
        send_frame();
        random_bytes += frame_buf.size();
        nframes++;
      end
    end
    calm = 1'b0;

    settle();
    repeat (10) @(negedge clk);
    if (sb.errors == 0 && sb.exp_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      if (sb.exp_q.size() != 0) begin
        $display("%0d expected results never arrived", sb.exp_q.size());
      end
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
